// File: rtl/mt_pkg.sv
// Shared constants and types for the Mersenne Twister generator.
package mt_pkg;

    localparam int unsigned MT_WORDS = 624;
    localparam int unsigned MT_SHIFT = 397;
    localparam int unsigned MT_CNT_W = $clog2(MT_WORDS);

    localparam logic [31:0] MT_MATRIX       = 32'h9908_B0DF;
    localparam logic [31:0] MT_UPPER        = 32'h8000_0000;
    localparam logic [31:0] MT_LOWER        = 32'h7FFF_FFFF;
    localparam logic [31:0] MT_TEMPER_B     = 32'h9D2C_5680;
    localparam logic [31:0] MT_TEMPER_C     = 32'hEFC6_0000;
    localparam logic [31:0] MT_SEED_MULT    = 32'd69069;
    localparam logic [31:0] MT_DEFAULT_SEED = 32'd4357;

    typedef enum logic [1:0] {
        ST_SEED,
        ST_READY,
        ST_TEMPER
    } t_state;

    typedef struct packed {
        logic        shift;
        logic        load_seed;
        logic [31:0] seed_word;
    } t_chain_ctrl;

endpackage

// File: rtl/mt_cell.sv
// One state word of the generator ring; takes the word on its input on a shift.
module mt_cell
    import mt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_shift,
    input  logic [31:0] i_d,
    output logic [31:0] o_q
);

    logic [31:0] r_word;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_word <= i_d;
        end
    end

    assign o_q = r_word;

endmodule

// File: rtl/mt_chain.sv
// Ring of state cells; the twist recurrence or a seed word feeds the tail.
module mt_chain
    import mt_pkg::*;
(
    input  logic        i_clk,
    input  t_chain_ctrl i_ctrl,
    output logic [31:0] o_new_word
);

    logic [31:0] w_q [MT_WORDS];
    logic [31:0] w_tail;
    logic [31:0] w_mix;
    logic [31:0] w_twist;

    // The head word, its neighbor and the word 397 ahead produce the next word.
    always_comb begin
        w_mix   = (w_q[0] & MT_UPPER) | (w_q[1] & MT_LOWER);
        w_twist = w_q[MT_SHIFT] ^ (w_mix >> 1) ^ (w_q[1][0] ? MT_MATRIX : 32'h0);
        w_tail  = i_ctrl.load_seed ? i_ctrl.seed_word : w_twist;
    end

    for (genvar g = 0; g < MT_WORDS; g++) begin : g_cell
        if (g == MT_WORDS - 1) begin : g_tail
            mt_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_ctrl.shift),
                .i_d     (w_tail),
                .o_q     (w_q[g])
            );
        end else begin : g_body
            mt_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_ctrl.shift),
                .i_d     (w_q[g+1]),
                .o_q     (w_q[g])
            );
        end
    end

    assign o_new_word = w_twist;

endmodule

// File: rtl/mt_temper.sv
// Output stage: temper the raw word and scale its low half by the limit.
module mt_temper
    import mt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_raw,
    input  logic [15:0] i_limit,
    output logic        o_valid,
    output logic [31:0] o_random_value,
    output logic [15:0] o_scaled_value
);

    logic        r_valid;
    logic [31:0] r_random;
    logic [15:0] r_scaled;
    logic [31:0] w_t1;
    logic [31:0] w_t2;
    logic [31:0] w_t3;
    logic [31:0] w_t4;
    logic [31:0] w_prod;

    always_comb begin
        w_t1   = i_raw ^ (i_raw >> 11);
        w_t2   = w_t1 ^ ((w_t1 << 7) & MT_TEMPER_B);
        w_t3   = w_t2 ^ ((w_t2 << 15) & MT_TEMPER_C);
        w_t4   = w_t3 ^ (w_t3 >> 18);
        w_prod = {16'd0, w_t4[15:0]} * {16'd0, i_limit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_random <= w_t4;
            r_scaled <= w_prod[31:16];
        end
    end

    assign o_valid        = r_valid;
    assign o_random_value = r_random;
    assign o_scaled_value = r_scaled;

endmodule

// File: rtl/mersenne_twister_generator.sv
// Top level of the MT19937 generator: seeding sequencer, cell ring, output stage.
//
//  channel | signals                                   | direction | handshake
//  --------+-------------------------------------------+-----------+---------------------
//  draw    | start, busy, i_range_limit                | in        | start && !busy
//  result  | o_result_valid, o_random_value,           | out       | strobe, one cycle
//          | o_scaled_value                            |           |
//  seed    | i_cfg_we, i_cfg_data                      | in        | i_cfg_we
//
//  A draw passes the word twisted out of the ring through r_raw and then through
//  the tempering and scaling stage; the strobe rises as busy drops, in the same
//  cycle, so a new draw is taken only once the last one's result is shown.
//  After reset and after each seed write the ring is refilled by shifting in
//  624 seed words, one per cycle; busy stays high until the fill is done.
//  The receiver cannot stall: each result is shown for exactly one cycle.
//  Reset is synchronous, active low; the ring words themselves are not reset.
//
//  The 624 words form a shift ring. Each draw computes the recurrence from the
//  head, the next word and the word 397 ahead, shifts it in at the tail and
//  emits it, so the store is twisted one word per draw instead of all at once.
module mersenne_twister_generator
    import mt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_range_limit,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    output logic        o_result_valid,
    output logic [31:0] o_random_value,
    output logic [15:0] o_scaled_value
);

    t_state              r_state;
    t_state              n_state;
    logic [31:0]         r_seed_x;
    logic [31:0]         n_seed_x;
    logic [MT_CNT_W-1:0] r_fill_cnt;
    logic [MT_CNT_W-1:0] n_fill_cnt;
    logic                r_draw_valid;
    logic [31:0]         r_raw;
    logic [15:0]         r_limit;

    logic                w_accept;
    logic                w_fill_done;
    logic [31:0]         w_new_word;
    t_chain_ctrl         w_ctrl;

    assign w_accept    = start && !busy;
    assign w_fill_done = (r_fill_cnt == MT_CNT_W'(MT_WORDS - 1));

    // Next state: a seed write always restarts the fill.
    always_comb begin
        n_state = r_state;
        if (i_cfg_we) begin
            n_state = ST_SEED;
        end else begin
            unique case (r_state)
                ST_SEED:   n_state = w_fill_done ? ST_READY : ST_SEED;
                ST_READY:  n_state = w_accept ? ST_TEMPER : ST_READY;
                ST_TEMPER: n_state = ST_READY;
                default:   n_state = ST_SEED;
            endcase
        end
    end

    // Outputs of the sequencer: ring control and busy.
    always_comb begin
        busy             = 1'b1;
        w_ctrl.shift     = 1'b0;
        w_ctrl.load_seed = 1'b0;
        w_ctrl.seed_word = r_seed_x;
        unique case (r_state)
            ST_SEED: begin
                w_ctrl.shift     = 1'b1;
                w_ctrl.load_seed = 1'b1;
            end
            ST_READY: begin
                busy         = 1'b0;
                w_ctrl.shift = start;
            end
            ST_TEMPER: begin
                busy = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // Seed word generator: odd seed, then successive products by 69069.
    always_comb begin
        n_seed_x   = r_seed_x;
        n_fill_cnt = r_fill_cnt;
        if (i_cfg_we) begin
            n_seed_x   = i_cfg_data | 32'h1;
            n_fill_cnt = '0;
        end else if (r_state == ST_SEED) begin
            n_seed_x   = r_seed_x * MT_SEED_MULT;
            n_fill_cnt = r_fill_cnt + MT_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SEED;
            r_seed_x     <= MT_DEFAULT_SEED | 32'h1;
            r_fill_cnt   <= '0;
            r_draw_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_seed_x     <= n_seed_x;
            r_fill_cnt   <= n_fill_cnt;
            r_draw_valid <= w_accept;
        end
    end

    // Hold the freshly twisted word and the limit for the output stage.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_raw   <= w_new_word;
            r_limit <= i_range_limit;
        end
    end

    mt_chain u_chain (
        .i_clk      (i_clk),
        .i_ctrl     (w_ctrl),
        .o_new_word (w_new_word)
    );

    mt_temper u_temper (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_draw_valid),
        .i_raw          (r_raw),
        .i_limit        (r_limit),
        .o_valid        (o_result_valid),
        .o_random_value (o_random_value),
        .o_scaled_value (o_scaled_value)
    );

    // Every accepted draw yields a result strobe.
    a_draw_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_result_valid)
        else $error("accepted draw produced no result");

    // A result strobe only follows an accepted draw.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, 2))
        else $error("result strobe without a draw");

    // The fill pass never runs past the end of the ring.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEED) |-> (r_fill_cnt < MT_CNT_W'(MT_WORDS)))
        else $error("seed fill count out of range");

endmodule

// File: test/mersenne_twister_generator_test.sv
// Self-checking testbench for the MT19937 generator: seeds, draws and twist-boundary checks.
`timescale 1ns / 1ps

module mersenne_twister_generator_test;
    import mt_pkg::*;

    // Any stretch this long with neither a draw transaction nor a result means a hang.
    // The longest correct quiet stretch is a full refill of the ring plus a short sender gap.
    localparam int unsigned IDLE_LIMIT = 3000;
    localparam int unsigned RANDOM_DRAWS = 1500;

    typedef struct packed {
        logic [31:0] random_value;
        logic [15:0] scaled_value;
    } t_draw_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] i_range_limit = '0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        o_result_valid;
    logic [31:0] o_random_value;
    logic [15:0] o_scaled_value;

    // Predictor copy of the generator: seed, word store and draw position.
    logic [31:0]  seed_reg;
    logic [31:0]  mt_words [0:MT_WORDS-1];
    int unsigned  next_slot;
    int unsigned  words_left;

    t_draw_result pending_draws [$];
    int unsigned  mismatch_count = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  burst_left = 1;

    mersenne_twister_generator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_range_limit  (i_range_limit),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_random_value (o_random_value),
        .o_scaled_value (o_scaled_value)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Seed the store: force the low bit, then each word is the previous one times 69069.
    // Clear the draw position so the next draw twists first.
    function automatic void refill_from_seed();
        logic [31:0] x;
        x = seed_reg | 32'd1;
        for (int i = 0; i < MT_WORDS; i++) begin
            mt_words[i] = x;
            x = x * MT_SEED_MULT;
        end
        next_slot = 0;
        words_left = 0;
    endfunction

    // Twist the whole store at once; the block does it one word per draw, same values.
    function automatic void regenerate_words();
        logic [31:0] nxt;
        logic [31:0] mix;
        for (int i = 0; i < MT_WORDS; i++) begin
            nxt = mt_words[(i + 1) % MT_WORDS];
            mix = (mt_words[i] & MT_UPPER) | (nxt & MT_LOWER);
            mt_words[i] = mt_words[(i + MT_SHIFT) % MT_WORDS] ^ (mix >> 1)
                          ^ (nxt[0] ? MT_MATRIX : 32'd0);
        end
    endfunction

    // Advance the predictor by one draw and return the tempered word and its scaled value.
    function automatic t_draw_result predict_draw(logic [15:0] limit);
        logic [31:0]  word;
        logic [31:0]  product;
        t_draw_result res;
        if (words_left == 0) begin
            // store used up: twist, hand out word 0
            regenerate_words();
            word = mt_words[0];
            next_slot = 1;
            words_left = MT_WORDS - 1;
        end else begin
            word = mt_words[next_slot % MT_WORDS];
            next_slot = next_slot + 1;
            words_left = words_left - 1;
        end
        word = word ^ (word >> 11);
        word = word ^ ((word << 7) & MT_TEMPER_B);
        word = word ^ ((word << 15) & MT_TEMPER_C);
        word = word ^ (word >> 18);
        product = {16'd0, word[15:0]} * {16'd0, limit};
        res.random_value = word;
        res.scaled_value = product[31:16];
        return res;
    endfunction

    // Offer one draw and hold it until the block takes it; keep start high on return
    // so a back-to-back draw needs no second assignment in the same step.
    task automatic send_draw(logic [15:0] limit);
        start <= 1'b1;
        i_range_limit <= limit;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        pending_draws.push_back(predict_draw(limit));
    endtask

    // Count down the current burst; at its end drop start for a random gap and pick
    // the next burst. Gaps land on both the accepting and the tempering state of a draw,
    // and the occasional long burst leaves stretches with no idling at all.
    task automatic pause_between_draws();
        burst_left = burst_left - 1;
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Drop start and wait until every expected result has come back, then hold
    // a few cycles more.
    task automatic wait_for_drain();
        start <= 1'b0;
        while (pending_draws.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the seed register once the block is idle and refill the predictor's store.
    task automatic load_seed(logic [31:0] value);
        wait_for_drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        seed_reg = value;
        refill_from_seed();
    endtask

    // First draws after reset come from the default seed; sweep the limit corners.
    task automatic test_default_seed();
        send_draw(16'h0000);
        pause_between_draws();
        send_draw(16'hFFFF);
        pause_between_draws();
        send_draw(16'h0001);
        pause_between_draws();
        send_draw(16'h8000);
        pause_between_draws();
        send_draw(16'h5555);
        pause_between_draws();
        send_draw(16'hAAAA);
        pause_between_draws();
    endtask

    // Seed extremes: zero has its low bit forced, so it must give the same stream as one.
    task automatic test_seed_extremes();
        load_seed(32'h0000_0000);
        repeat (3) begin
            send_draw(16'($urandom_range(0, 65535)));
            pause_between_draws();
        end
        load_seed(32'hFFFF_FFFF);
        repeat (3) begin
            send_draw(16'($urandom_range(0, 65535)));
            pause_between_draws();
        end
        load_seed(32'h0000_0001);
        repeat (3) begin
            send_draw(16'($urandom_range(0, 65535)));
            pause_between_draws();
        end
    endtask

    // Reseed partway into a store: the draw position must restart from a fresh twist.
    task automatic test_reseed_mid_store();
        load_seed($urandom());
        repeat (5) begin
            send_draw(16'($urandom_range(0, 65535)));
            pause_between_draws();
        end
        load_seed($urandom());
        repeat (3) begin
            send_draw(16'($urandom_range(0, 65535)));
            pause_between_draws();
        end
    endtask

    // Random draws: one long phase crossing two twist boundaries, then short phases
    // each opened by a new seed, now and then an extreme one.
    task automatic test_random_draws();
        int unsigned drawn;
        int unsigned phase_len;
        logic [15:0] limit;
        drawn = 0;
        phase_len = 1300;
        while (drawn < RANDOM_DRAWS) begin
            if (drawn != 0) begin
                phase_len = $urandom_range(20, 120);
                if ($urandom_range(0, 9) == 0)
                    load_seed($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000);
                else
                    load_seed($urandom());
            end
            repeat (phase_len) begin
                if ($urandom_range(0, 7) == 0) begin
                    case ($urandom_range(0, 3))
                        0: limit = 16'h0000;
                        1: limit = 16'hFFFF;
                        2: limit = 16'h0001;
                        default: limit = 16'h8000;
                    endcase
                end else begin
                    limit = 16'($urandom_range(0, 65535));
                end
                send_draw(limit);
                pause_between_draws();
            end
            drawn = drawn + phase_len;
        end
    endtask

    // Compare each strobed result, field by field, with the oldest pending draw.
    always @(posedge i_clk) begin
        t_draw_result want;
        if (i_rst_n && o_result_valid) begin
            if (pending_draws.size() == 0) begin
                $display("%0t: result with no draw pending: expected none, got %h / %h",
                         $time, o_random_value, o_scaled_value);
                mismatch_count = mismatch_count + 1;
            end else begin
                want = pending_draws.pop_front();
                if (o_random_value !== want.random_value) begin
                    $display("%0t: random_value expected %h, got %h",
                             $time, want.random_value, o_random_value);
                    mismatch_count = mismatch_count + 1;
                end
                if (o_scaled_value !== want.scaled_value) begin
                    $display("%0t: scaled_value expected %h, got %h",
                             $time, want.scaled_value, o_scaled_value);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // Watchdog: reset the count on any draw transaction or result, give up on a long hang.
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_result_valid === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired with %0d draws pending", $time,
                     pending_draws.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        // Predictor reset state: default seed, store filled, first draw twists.
        seed_reg = MT_DEFAULT_SEED;
        refill_from_seed();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_seed();
        test_seed_extremes();
        test_reseed_mid_store();
        test_random_draws();

        // Let the last results come back, then allow a few spare cycles.
        wait_for_drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
